// ----- rtl/cable_rig_position_tracker_macros.svh -----
// assertion macros for the checker file
`ifndef CABLE_RIG_POSITION_TRACKER_MACROS_SVH
`define CABLE_RIG_POSITION_TRACKER_MACROS_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define CRPT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> cons) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define CRPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> cons) \
        else $error(msg);

`endif

// ----- rtl/crpt_pkg.sv -----
// shared types, constants and microcode table of the cable rig position tracker
package crpt_pkg;

    localparam int NUM_BASES     = 4;
    localparam int COORD_BITS    = 16;
    localparam int BASE_BITS     = 16;
    localparam int OUT_BITS      = 16;
    localparam int DELTA_BITS    = 16;
    localparam int RAD_BITS      = 17;
    localparam int OFS_BITS      = 18;
    localparam int STEP_BITS     = 10;
    localparam int CFG_BITS      = 48;
    localparam int CFG_IDX_BITS  = 3;
    localparam int BASE_IDX_BITS = $clog2(NUM_BASES);
    localparam int DIFF_BITS     = ((COORD_BITS > BASE_BITS) ? COORD_BITS : BASE_BITS) + 1;
    localparam int SQ_BITS       = 2 * DIFF_BITS;
    localparam int DIST_BITS     = SQ_BITS + 2;
    localparam int PC_BITS       = 3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_POS_0 = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_POS_1 = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_POS_2 = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_POS_3 = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_A   = CFG_IDX_BITS'(4);
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_B   = CFG_IDX_BITS'(5);
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE  = CFG_IDX_BITS'(6);

    // microprogram addresses
    localparam logic [PC_BITS-1:0] UC_WAIT = PC_BITS'(0);
    localparam logic [PC_BITS-1:0] UC_SQ_X = PC_BITS'(1);
    localparam logic [PC_BITS-1:0] UC_SQ_Y = PC_BITS'(2);
    localparam logic [PC_BITS-1:0] UC_SQ_Z = PC_BITS'(3);
    localparam logic [PC_BITS-1:0] UC_SQ_R = PC_BITS'(4);
    localparam logic [PC_BITS-1:0] UC_CMP  = PC_BITS'(5);
    localparam logic [PC_BITS-1:0] UC_OUT  = PC_BITS'(6);

    typedef enum logic [1:0] {MUL_X, MUL_Y, MUL_Z, MUL_R} mul_sel_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
    typedef enum logic [1:0] {JC_NEXT, JC_INPUT, JC_MORE, JC_OUT} jcond_t;

    typedef struct packed {
        mul_sel_t             mul_sel;
        acc_op_t              acc_op;
        logic                 rad_load;
        logic                 cmp_en;
        logic                 in_en;
        logic                 out_en;
        jcond_t               jcond;
        logic [PC_BITS-1:0]   target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic more_bases;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic signed [DELTA_BITS-1:0] rope_delta_0;
        logic signed [DELTA_BITS-1:0] rope_delta_1;
        logic signed [DELTA_BITS-1:0] rope_delta_2;
        logic signed [DELTA_BITS-1:0] rope_delta_3;
    } in_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] pos_x;
        logic signed [OUT_BITS-1:0] pos_y;
        logic signed [OUT_BITS-1:0] pos_z;
        logic [NUM_BASES-1:0]       moved_mask;
    } out_t;

    function automatic ctrl_t ucode_rom(input logic [PC_BITS-1:0] pc);
        ctrl_t cw;
        cw = '{mul_sel: MUL_X, acc_op: ACC_HOLD, rad_load: 1'b0, cmp_en: 1'b0,
               in_en: 1'b0, out_en: 1'b0, jcond: JC_NEXT, target: UC_WAIT};
        unique case (pc)
            UC_WAIT: begin
                cw.in_en  = 1'b1;
                cw.jcond  = JC_INPUT;
                cw.target = UC_SQ_X;
            end
            UC_SQ_X: begin
                cw.mul_sel  = MUL_X;
                cw.rad_load = 1'b1;
            end
            UC_SQ_Y: begin
                cw.mul_sel = MUL_Y;
                cw.acc_op  = ACC_LOAD;
            end
            UC_SQ_Z: begin
                cw.mul_sel = MUL_Z;
                cw.acc_op  = ACC_ADD;
            end
            UC_SQ_R: begin
                cw.mul_sel = MUL_R;
                cw.acc_op  = ACC_ADD;
            end
            UC_CMP: begin
                cw.cmp_en = 1'b1;
                cw.jcond  = JC_MORE;
                cw.target = UC_SQ_X;
            end
            UC_OUT: begin
                cw.out_en = 1'b1;
                cw.jcond  = JC_OUT;
                cw.target = UC_WAIT;
            end
            default: begin
                // unused address, falls through to wait by counter wrap
                cw.jcond = JC_NEXT;
            end
        endcase
        return cw;
    endfunction

endpackage

// ----- rtl/crpt_useq.sv -----
// microcode sequencer: step counter, control table lookup and jumps
module crpt_useq (
    input  logic              aclk,
    input  logic              aresetn,
    input  crpt_pkg::status_t status,
    output crpt_pkg::ctrl_t   ctrl
);

    logic [crpt_pkg::PC_BITS-1:0] pc_reg;
    logic [crpt_pkg::PC_BITS-1:0] pc_next;

    assign ctrl = crpt_pkg::ucode_rom(pc_reg);

    always_comb begin
        unique case (ctrl.jcond)
            crpt_pkg::JC_NEXT:  pc_next = pc_reg + crpt_pkg::PC_BITS'(1);
            crpt_pkg::JC_INPUT: pc_next = status.in_valid ? ctrl.target : pc_reg;
            crpt_pkg::JC_MORE:  pc_next = status.more_bases ? ctrl.target
                                                            : pc_reg + crpt_pkg::PC_BITS'(1);
            crpt_pkg::JC_OUT:   pc_next = status.out_free ? ctrl.target : pc_reg;
            default:            pc_next = crpt_pkg::UC_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= crpt_pkg::UC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- rtl/crpt_dpath.sv -----
// datapath: config registers, radius accumulators, shared squarer, position and result register
module crpt_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  crpt_pkg::ctrl_t                     ctrl,
    output crpt_pkg::status_t                   status,
    input  logic                                s_valid,
    input  crpt_pkg::in_t                       s_data,
    input  logic                                m_ready,
    output logic                                m_valid,
    output crpt_pkg::out_t                      m_data,
    input  logic                                cfg_wr_en,
    input  logic [crpt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [crpt_pkg::CFG_BITS-1:0]       cfg_wr_data
);

    localparam int NB  = crpt_pkg::NUM_BASES;
    localparam int BB  = crpt_pkg::BASE_BITS;
    localparam int RB  = crpt_pkg::RAD_BITS;
    localparam int OB  = crpt_pkg::OFS_BITS;
    localparam int DB  = crpt_pkg::DIFF_BITS;
    localparam int SB  = crpt_pkg::SQ_BITS;
    localparam int AB  = crpt_pkg::DIST_BITS;
    localparam int CB  = crpt_pkg::COORD_BITS;
    localparam int IB  = crpt_pkg::BASE_IDX_BITS;
    localparam int OUB = crpt_pkg::OUT_BITS;

    localparam logic signed [OB:0] OFS_MAX_W = (OB+1)'(2**(OB-1) - 1);
    localparam logic signed [OB:0] OFS_MIN_W = -OFS_MAX_W - (OB+1)'(1);
    localparam logic signed [OB:0] RAD_MAX_W = (OB+1)'(2**RB - 1);
    localparam logic signed [DB:0] CRD_MAX_W = (DB+1)'(2**(CB-1) - 1);
    localparam logic signed [DB:0] CRD_MIN_W = -CRD_MAX_W - (DB+1)'(1);

    // configuration
    logic [3*BB-1:0]                   base_reg     [NB];
    logic [RB-1:0]                     init_rad_reg [NB];
    logic [crpt_pkg::STEP_BITS-1:0]    step_reg;

    // state
    logic signed [OB-1:0]  ofs_reg  [NB];
    logic signed [OB-1:0]  ofs_next [NB];
    logic signed [OB:0]    ofs_sum  [NB];
    logic signed [DB-1:0]  delta_ext[NB];
    logic signed [CB-1:0]  pos_reg  [3];
    logic signed [CB-1:0]  pos_next [3];
    logic [IB-1:0]         base_idx_reg;
    logic [NB-1:0]         mask_reg;
    logic [RB-1:0]         rad_reg;
    logic [RB-1:0]         rad_next;
    logic signed [OB:0]    rad_sum;
    logic signed [SB-1:0]  prod_reg;
    logic [AB-1:0]         acc_reg;
    logic [AB-1:0]         sq_ext;
    logic                  hit;
    logic                  in_acc;
    logic                  m_valid_reg;
    crpt_pkg::out_t        m_data_reg;

    // per-axis datapath
    logic [3*BB-1:0]       base_sel;
    logic signed [DB-1:0]  pos_ext  [3];
    logic signed [DB-1:0]  base_ext [3];
    logic signed [DB-1:0]  diff     [3];
    logic signed [DB:0]    moved    [3];
    logic signed [DB:0]    step_ext;
    // one bit wider than a difference so the full radius range stays positive
    logic signed [DB:0]    mul_a;
    logic signed [SB-1:0]  prod;

    assign in_acc = ctrl.in_en & s_valid;

    // config writes, indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NB; i++) begin
                base_reg[i]     <= '0;
                init_rad_reg[i] <= '0;
            end
            step_reg <= crpt_pkg::STEP_BITS'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                crpt_pkg::CFG_BASE_POS_0: base_reg[0] <= cfg_wr_data[3*BB-1:0];
                crpt_pkg::CFG_BASE_POS_1: base_reg[1] <= cfg_wr_data[3*BB-1:0];
                crpt_pkg::CFG_BASE_POS_2: base_reg[2] <= cfg_wr_data[3*BB-1:0];
                crpt_pkg::CFG_BASE_POS_3: base_reg[3] <= cfg_wr_data[3*BB-1:0];
                crpt_pkg::CFG_RADIUS_A: begin
                    init_rad_reg[0] <= cfg_wr_data[RB-1:0];
                    init_rad_reg[1] <= cfg_wr_data[2*RB-1:RB];
                end
                crpt_pkg::CFG_RADIUS_B: begin
                    init_rad_reg[2] <= cfg_wr_data[RB-1:0];
                    init_rad_reg[3] <= cfg_wr_data[2*RB-1:RB];
                end
                crpt_pkg::CFG_STEP_SIZE: step_reg <= cfg_wr_data[crpt_pkg::STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // saturating rope accumulators
    assign delta_ext[0] = DB'(s_data.rope_delta_0);
    assign delta_ext[1] = DB'(s_data.rope_delta_1);
    assign delta_ext[2] = DB'(s_data.rope_delta_2);
    assign delta_ext[3] = DB'(s_data.rope_delta_3);

    always_comb begin
        for (int i = 0; i < NB; i++) begin
            ofs_sum[i] = (OB+1)'(ofs_reg[i]) + (OB+1)'(delta_ext[i]);
            if (ofs_sum[i] > OFS_MAX_W) begin
                ofs_next[i] = OB'(OFS_MAX_W);
            end else if (ofs_sum[i] < OFS_MIN_W) begin
                ofs_next[i] = OB'(OFS_MIN_W);
            end else begin
                ofs_next[i] = OB'(ofs_sum[i]);
            end
        end
    end

    // clamped radius of the current base
    always_comb begin
        rad_sum = $signed((OB+1)'(init_rad_reg[base_idx_reg])) + (OB+1)'(ofs_reg[base_idx_reg]);
        if (rad_sum < 0) begin
            rad_next = '0;
        end else if (rad_sum > RAD_MAX_W) begin
            rad_next = RB'(RAD_MAX_W);
        end else begin
            rad_next = RB'(rad_sum);
        end
    end

    // differences and correction candidates
    assign base_sel = base_reg[base_idx_reg];
    assign step_ext = $signed((DB+1)'(step_reg));

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            pos_ext[a]  = DB'(pos_reg[a]);
            base_ext[a] = DB'($signed(base_sel[a*BB +: BB]));
            diff[a]     = pos_ext[a] - base_ext[a];
            moved[a]    = (pos_ext[a] < base_ext[a]) ? (DB+1)'(pos_ext[a]) + step_ext
                                                     : (DB+1)'(pos_ext[a]) - step_ext;
            if (moved[a] > CRD_MAX_W) begin
                pos_next[a] = CB'(CRD_MAX_W);
            end else if (moved[a] < CRD_MIN_W) begin
                pos_next[a] = CB'(CRD_MIN_W);
            end else begin
                pos_next[a] = CB'(moved[a]);
            end
        end
    end

    // shared squarer
    always_comb begin
        case (ctrl.mul_sel)
            crpt_pkg::MUL_X: mul_a = (DB+1)'(diff[0]);
            crpt_pkg::MUL_Y: mul_a = (DB+1)'(diff[1]);
            crpt_pkg::MUL_Z: mul_a = (DB+1)'(diff[2]);
            default:         mul_a = $signed((DB+1)'(rad_reg));
        endcase
    end

    assign prod   = SB'(mul_a) * SB'(mul_a);
    assign sq_ext = AB'($unsigned(prod_reg));
    // at the compare step prod_reg holds radius squared and acc_reg the distance squared
    assign hit    = acc_reg > sq_ext;

    always_ff @(posedge aclk) begin
        prod_reg <= prod;
        if (ctrl.rad_load) begin
            rad_reg <= rad_next;
        end
        case (ctrl.acc_op)
            crpt_pkg::ACC_LOAD: acc_reg <= sq_ext;
            crpt_pkg::ACC_ADD:  acc_reg <= acc_reg + sq_ext;
            default:            acc_reg <= acc_reg;
        endcase
    end

    // tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NB; i++) begin
                ofs_reg[i] <= '0;
            end
            for (int a = 0; a < 3; a++) begin
                pos_reg[a] <= '0;
            end
            base_idx_reg <= '0;
            mask_reg     <= '0;
        end else begin
            if (in_acc) begin
                ofs_reg      <= ofs_next;
                base_idx_reg <= '0;
                mask_reg     <= '0;
            end
            if (ctrl.cmp_en) begin
                if (hit) begin
                    pos_reg                <= pos_next;
                    mask_reg[base_idx_reg] <= 1'b1;
                end
                if (status.more_bases) begin
                    base_idx_reg <= base_idx_reg + IB'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_en && status.out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_en && status.out_free) begin
            m_data_reg.pos_x      <= pos_ext[0][OUB-1:0];
            m_data_reg.pos_y      <= pos_ext[1][OUB-1:0];
            m_data_reg.pos_z      <= pos_ext[2][OUB-1:0];
            m_data_reg.moved_mask <= mask_reg;
        end
    end

    assign status.in_valid   = s_valid;
    assign status.more_bases = (base_idx_reg != IB'(NB - 1));
    assign status.out_free   = ~m_valid_reg | m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/cable_rig_position_tracker.sv -----
// top level of the cable rig position tracker
//
//  channel  | handshake          | payload            | direction
//  ---------+--------------------+--------------------+----------
//  s_       | s_valid / s_ready  | s_data  (in_t)     | in
//  m_       | m_valid / m_ready  | m_data  (out_t)    | out
//  cfg_     | cfg_wr_en          | cfg_index, data    | in
//
//  sequence: an accept step, then for each base through the single shared squarer
//    the three axis squares, the radius square and the compare, then a step to
//    load the result register
//  reset: synchronous on aresetn low, configuration registers back to defaults, rope
//    accumulators and position to zero, no clearing pass
//  stalls: the sequencer waits at the output step while a previous result is unread,
//    the next transaction is taken while a finished result waits in the output register
module cable_rig_position_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input transactions: four rope deltas
    input  logic                                s_valid,
    output logic                                s_ready,
    input  crpt_pkg::in_t                       s_data,
    // result transactions: position and correction mask
    output logic                                m_valid,
    input  logic                                m_ready,
    output crpt_pkg::out_t                      m_data,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [crpt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [crpt_pkg::CFG_BITS-1:0]       cfg_wr_data
);

    crpt_pkg::ctrl_t   ctrl;
    crpt_pkg::status_t status;

    // control word of the current step
    crpt_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // arithmetic and storage driven by the control word
    crpt_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .status      (status),
        .s_valid     (s_valid),
        .s_data      (s_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // ready only at the wait step of the program
    assign s_ready = ctrl.in_en;

endmodule

// ----- rtl/crpt_checker.sv -----
// port-level checker for the cable rig position tracker and its bind
`include "cable_rig_position_tracker_macros.svh"

module crpt_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input crpt_pkg::out_t m_data
);

    // stalled result holds
    `CRPT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // busy right after a transaction is taken
    `CRPT_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready right after accept")

    // still busy once all four bases have been worked through
    `CRPT_ASSERT_IMPL(a_busy_through_bases, s_valid && s_ready, ##21 !s_ready, "ready before output step")

    // a new result only comes out of the busy output step
    `CRPT_ASSERT_IMPL(a_result_from_busy, $rose(m_valid), $past(!s_ready), "result loaded while idle")

endmodule

bind cable_rig_position_tracker crpt_checker u_crpt_checker (.*);

// ----- tb/tb_top.sv -----
// testbench for the cable rig position tracker: stimulus, position predictor and result checks
`timescale 1ns / 1ps
module tb_top;
    import crpt_pkg::*;

    localparam int  HALF_PERIOD     = 6;
    localparam int  RESET_CYCLES    = 12;
    localparam int  PHASES          = 12;
    localparam int  ITEMS_PER_PHASE = 150;
    localparam int  QUIET_LIMIT     = 2000;
    localparam int  DRAIN_CYCLES    = 40;
    localparam int  STEER_BAND      = 2000;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = CFG_IDX_BITS'(7);

    // how spread out base coordinates and initial radii are in one phase
    typedef enum int {SPREAD_FULL, SPREAD_NEAR, SPREAD_CORNER} spread_t;
    // result side stall patterns
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_THIRDS, SINK_HOLD} sink_mode_t;

    // predicts the position updates and checks the ones the block returns
    class rig_scoreboard;
        localparam longint OFS_HI      = (longint'(1) << (OFS_BITS - 1)) - 1;
        localparam longint OFS_LO      = -OFS_HI - 1;
        localparam longint RAD_HI      = (longint'(1) << RAD_BITS) - 1;
        localparam longint COORD_HI    = (longint'(1) << (COORD_BITS - 1)) - 1;
        localparam longint COORD_LO    = -COORD_HI - 1;

        logic [CFG_BITS-1:0]     base_xyz [NUM_BASES];
        logic [2*RAD_BITS-1:0]   radius_pair [2];
        logic [STEP_BITS-1:0]    step_mm;
        longint                  rope_ofs [NUM_BASES];
        longint                  pos_mm [3];
        out_t                    expected_fixes [$];
        int                      errors;
        int                      fixes_checked;
        int                      corrections;
        int                      pinned_steps;

        function new();
            int i;
            for (i = 0; i < NUM_BASES; i++) begin
                base_xyz[i] = '0;
                rope_ofs[i] = 0;
            end
            radius_pair[0] = '0;
            radius_pair[1] = '0;
            step_mm        = STEP_BITS'(1);
            for (i = 0; i < 3; i++) pos_mm[i] = 0;
            errors        = 0;
            fixes_checked = 0;
            corrections   = 0;
            pinned_steps  = 0;
        endfunction

        static function longint clamp_mm(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
            case (idx)
                CFG_BASE_POS_0, CFG_BASE_POS_1, CFG_BASE_POS_2, CFG_BASE_POS_3:
                    base_xyz[idx] = data;
                CFG_RADIUS_A:  radius_pair[0] = data[2*RAD_BITS-1:0];
                CFG_RADIUS_B:  radius_pair[1] = data[2*RAD_BITS-1:0];
                CFG_STEP_SIZE: step_mm = data[STEP_BITS-1:0];
                default: ;  // no register behind this index
            endcase
        endfunction

        // accumulate rope deltas, then let each base pull or push the load in turn
        function void track_ropes(in_t item);
            logic [NUM_BASES-1:0][DELTA_BITS-1:0] deltas;
            logic [NUM_BASES-1:0]                 mask;
            longint                               b [3];
            longint                               r, dist2, diff, p, step;
            out_t                                 fix;
            int                                   i, a;
            deltas = item;
            mask   = '0;
            step   = longint'(step_mm);
            for (i = 0; i < NUM_BASES; i++)
                rope_ofs[i] = clamp_mm(rope_ofs[i] +
                                       longint'($signed(deltas[NUM_BASES-1-i])),
                                       OFS_LO, OFS_HI);
            for (i = 0; i < NUM_BASES; i++) begin
                r = clamp_mm(longint'(radius_pair[i/2][RAD_BITS*(i%2) +: RAD_BITS]) +
                             rope_ofs[i], 0, RAD_HI);
                dist2 = 0;
                for (a = 0; a < 3; a++) begin
                    b[a]  = longint'($signed(base_xyz[i][BASE_BITS*a +: BASE_BITS]));
                    diff  = pos_mm[a] - b[a];
                    dist2 += diff * diff;
                end
                // strictly outside the rope sphere, equal distance leaves it alone
                if (dist2 > r * r) begin
                    mask[i] = 1'b1;
                    corrections++;
                    for (a = 0; a < 3; a++) begin
                        p = (pos_mm[a] < b[a]) ? pos_mm[a] + step : pos_mm[a] - step;
                        pos_mm[a] = clamp_mm(p, COORD_LO, COORD_HI);
                        if (pos_mm[a] != p) pinned_steps++;
                    end
                end
            end
            fix.pos_x      = OUT_BITS'(pos_mm[0]);
            fix.pos_y      = OUT_BITS'(pos_mm[1]);
            fix.pos_z      = OUT_BITS'(pos_mm[2]);
            fix.moved_mask = mask;
            expected_fixes = {expected_fixes, fix};
        endfunction

        function void flag(string field, longint want, longint got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_fix(out_t got);
            out_t want;
            if (expected_fixes.size() == 0) begin
                errors++;
                $display("%0t: position update with none expected, got x=%0d y=%0d z=%0d mask=%b",
                         $time, got.pos_x, got.pos_y, got.pos_z, got.moved_mask);
                return;
            end
            want = expected_fixes.pop_front();
            fixes_checked++;
            if (got.pos_x !== want.pos_x) flag("pos_x", $signed(want.pos_x), $signed(got.pos_x));
            if (got.pos_y !== want.pos_y) flag("pos_y", $signed(want.pos_y), $signed(got.pos_y));
            if (got.pos_z !== want.pos_z) flag("pos_z", $signed(want.pos_z), $signed(got.pos_z));
            if (got.moved_mask !== want.moved_mask)
                flag("moved_mask", want.moved_mask, got.moved_mask);
        endfunction

        function int pending();
            return expected_fixes.size();
        endfunction
    endclass

    // clock, reset and block ports, the ones driven here known from time zero
    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    in_t                     s_data      = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    out_t                    m_data;
    logic                    cfg_wr_en   = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index   = CFG_BASE_POS_0;
    logic [CFG_BITS-1:0]     cfg_wr_data = '0;

    rig_scoreboard sb;

    // sender bookkeeping: burst length and a running copy of the rope accumulators
    int         burst_left = 0;
    longint     rope_drift [NUM_BASES] = '{0, 0, 0, 0};
    int         settings_count = 0;

    // receiver stall pattern state
    sink_mode_t sink_mode = SINK_OPEN;
    int         sink_left = 0;
    int         sink_tick = 0;

    int         quiet_cycles = 0;

    cable_rig_position_tracker dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // monitor: every accepted transaction is seen at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.track_ropes(s_data);
            if (m_valid && m_ready) sb.check_fix(m_data);
        end
    end

    // receiver: switches between open, coin-flip, periodic and long-hold stalls
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (sink_left == 0) begin
                sink_mode <= sink_mode_t'(int'($urandom_range(0, 3)));
                sink_left <= $urandom_range(100, 400);
            end else begin
                sink_left <= sink_left - 1;
            end
            sink_tick <= sink_tick + 1;
            case (sink_mode)
                SINK_OPEN:   m_ready <= 1'b1;
                SINK_COIN:   m_ready <= 1'($urandom_range(0, 1));
                SINK_THIRDS: m_ready <= (sink_tick % 3 == 0);
                default:     m_ready <= (sink_tick % 40 >= 34);
            endcase
        end
    end

    // watchdog: too long without any transaction or register write means a hang
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d updates still owed",
                     $time, QUIET_LIMIT, sb.pending());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic in_t ropes(int d0, int d1, int d2, int d3);
        in_t r;
        r.rope_delta_0 = DELTA_BITS'(d0);
        r.rope_delta_1 = DELTA_BITS'(d1);
        r.rope_delta_2 = DELTA_BITS'(d2);
        r.rope_delta_3 = DELTA_BITS'(d3);
        return r;
    endfunction

    // base word: x low, y middle, z high
    function automatic logic [CFG_BITS-1:0] base_at(int x, int y, int z);
        return {BASE_BITS'(z), BASE_BITS'(y), BASE_BITS'(x)};
    endfunction

    function automatic logic [BASE_BITS-1:0] pick_coord(spread_t spread);
        case (spread)
            SPREAD_FULL: return BASE_BITS'($urandom);
            SPREAD_NEAR: return BASE_BITS'(int'($urandom_range(0, 3000)) - 1500);
            default: begin
                case ($urandom_range(0, 2))
                    0:       return 16'h7fff;
                    1:       return 16'h8000;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_base(spread_t spread);
        return {pick_coord(spread), pick_coord(spread), pick_coord(spread)};
    endfunction

    function automatic logic [RAD_BITS-1:0] pick_radius(spread_t spread);
        case (spread)
            SPREAD_FULL: return RAD_BITS'($urandom);
            SPREAD_NEAR: return RAD_BITS'($urandom_range(0, 4000));
            default:     return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    function automatic logic [STEP_BITS-1:0] pick_step();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll <= 2) return '1;
        if (roll <= 6) return STEP_BITS'($urandom_range(1, 16));
        return STEP_BITS'($urandom_range(0, 1023));
    endfunction

    // mostly small deltas that keep the accumulator near zero so radii track distances
    function automatic logic [DELTA_BITS-1:0] pick_delta(longint drift);
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return DELTA_BITS'($urandom);
        if (roll == 1) begin
            case ($urandom_range(0, 3))
                0:       return 16'h7fff;
                1:       return 16'h8000;
                2:       return 16'hffff;
                default: return 16'h0000;
            endcase
        end
        if (drift > STEER_BAND)  return DELTA_BITS'(-int'($urandom_range(0, 6000)));
        if (drift < -STEER_BAND) return DELTA_BITS'($urandom_range(0, 6000));
        return DELTA_BITS'(int'($urandom_range(0, 128)) - 64);
    endfunction

    // send one transaction, with a random gap at the start of each burst
    task automatic offer_ropes(input in_t item);
        logic [NUM_BASES-1:0][DELTA_BITS-1:0] deltas;
        int gap;
        int i;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 25);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
        end
        burst_left--;
        deltas = item;
        for (i = 0; i < NUM_BASES; i++)
            rope_drift[i] = rig_scoreboard::clamp_mm(
                rope_drift[i] + longint'($signed(deltas[NUM_BASES-1-i])),
                rig_scoreboard::OFS_LO, rig_scoreboard::OFS_HI);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // one register write, predictor updated alongside
    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic program_rig(input logic [CFG_BITS-1:0] b0, b1, b2, b3,
                               input logic [CFG_BITS-1:0] rad_a, rad_b, step);
        cfg_write(CFG_BASE_POS_0, b0);
        cfg_write(CFG_BASE_POS_1, b1);
        cfg_write(CFG_BASE_POS_2, b2);
        cfg_write(CFG_BASE_POS_3, b3);
        cfg_write(CFG_RADIUS_A, rad_a);
        cfg_write(CFG_RADIUS_B, rad_b);
        cfg_write(CFG_STEP_SIZE, step);
        settings_count++;
    endtask

    // stop sending and wait for every owed update; each transaction yields one
    task automatic settle_rig();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        spread_t                  spread;
        logic [CFG_BITS-1:0]      b [NUM_BASES];
        logic [STEP_BITS-1:0]     step;
        int                       phase, k, i;

        sb = new();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // reset defaults: all bases at the origin with zero radius, equal distance everywhere
        offer_ropes(ropes(0, 0, 0, 0));
        // delta extremes, base 1 and base 3 radii go negative and clamp to zero
        offer_ropes(ropes(32767, -32768, 1, -1));
        offer_ropes(ropes(-32767, 32767, -1, 1));
        settle_rig();

        // spare index must not land anywhere
        cfg_write(CFG_SPARE, '1);
        // base 0 at distance 5 with radius 5, base 2 radius at the top, full step
        program_rig(base_at(3, 4, 0), base_at(32767, 32767, 32767),
                    base_at(-32768, -32768, -32768), base_at(100, -100, 0),
                    {14'd0, 17'd1, 17'd5}, {14'd0, 17'd0, 17'h1ffff}, 48'd1023);
        offer_ropes(ropes(0, 0, 0, 0));
        // drive every accumulator into its upper limit, radii clamp high
        repeat (5) offer_ropes(ropes(32767, 32767, 32767, 32767));
        // then into its lower limit, radii clamp to zero and every base corrects
        repeat (9) offer_ropes(ropes(-32768, -32768, -32768, -32768));
        settle_rig();

        // zero step: mask bits still set, position frozen
        cfg_write(CFG_STEP_SIZE, '0);
        repeat (2) offer_ropes(ropes(0, 0, 0, 0));
        repeat (4) offer_ropes(ropes(32767, 32767, 32767, 32767));

        // random phases; the first two pin all bases to one corner to force saturation
        for (phase = 0; phase < PHASES; phase++) begin
            settle_rig();
            if (phase < 2) begin
                for (i = 0; i < NUM_BASES; i++)
                    b[i] = (phase == 0) ? base_at(32767, 32767, 32767)
                                        : base_at(-32768, -32768, -32768);
                spread = SPREAD_NEAR;
                step   = '1;
            end else begin
                spread = spread_t'(int'($urandom_range(0, 2)));
                for (i = 0; i < NUM_BASES; i++) b[i] = pick_base(spread);
                step = pick_step();
            end
            // upper bits beyond each register are junk the block must drop
            program_rig(b[0], b[1], b[2], b[3],
                        {14'($urandom), pick_radius(spread), pick_radius(spread)},
                        {14'($urandom), pick_radius(spread), pick_radius(spread)},
                        {38'($urandom), step});
            if ($urandom_range(0, 3) == 0)
                cfg_write(CFG_SPARE, {16'($urandom), 32'($urandom)});
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                offer_ropes({pick_delta(rope_drift[0]), pick_delta(rope_drift[1]),
                             pick_delta(rope_drift[2]), pick_delta(rope_drift[3])});
        end

        settle_rig();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d position updates across %0d register settings",
                 sb.fixes_checked, settings_count);
        $display("%0d base corrections, %0d axis steps held at the coordinate limits",
                 sb.corrections, sb.pinned_steps);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- cable_rig_position_tracker.f -----
+incdir+rtl
rtl/crpt_pkg.sv
rtl/crpt_useq.sv
rtl/crpt_dpath.sv
rtl/cable_rig_position_tracker.sv
rtl/crpt_checker.sv
tb/tb_top.sv
